// ===== hdl/mdpg_pkg.sv =====
// Package for the multichannel delay pulse generator.
// Holds channel count, command layout and character codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mdpg_pkg;

	localparam int CHANNELS = 4;
	localparam int CMD_LEN = 11;
	localparam int LEVELS_W = 4;

	localparam logic [3:0] LAST_POS = 4'(CMD_LEN - 1);

	localparam logic [7:0] CHAR_A = 8'h41;
	localparam logic [7:0] CHAR_T = 8'h54;
	localparam logic [7:0] CHAR_PLUS = 8'h2B;
	localparam logic [7:0] CHAR_C = 8'h43;
	localparam logic [7:0] CHAR_EQ = 8'h3D;
	localparam logic [7:0] DIGIT_BASE = 8'd48;
	localparam logic [7:0] DIGIT_MAX = 8'd9;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef logic [3:0] count_t;
	typedef logic [7:0] char_t;

endpackage
`default_nettype wire

// ===== hdl/mdpg_if.sv =====
// Handshake interfaces for the input item channel and the result channel.
// Depends on mdpg_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none
interface mdpg_in_if;
	logic valid;
	logic ready;
	logic operation;
	mdpg_pkg::char_t rx_byte;

	modport source (output valid, output operation, output rx_byte, input ready);
	modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

interface mdpg_out_if;
	logic valid;
	logic ready;
	logic [mdpg_pkg::LEVELS_W-1:0] outputs_on;
	logic command_error;
	logic command_applied;

	modport source (output valid, output outputs_on, output command_error,
		output command_applied, input ready);
	modport sink (input valid, input outputs_on, input command_error,
		input command_applied, output ready);
endinterface
`default_nettype wire

// ===== hdl/multichannel_delay_pulse_generator.sv =====
// Top level of the multichannel delay pulse generator: command parser and channel timers.
// Depends on mdpg_pkg and the handshake interfaces in mdpg_if.sv.
//
// Channel  Role    Payload
// item     sink    operation, rx_byte
// result   source  outputs_on, command_error, command_applied
//
// One transaction is accepted per cycle while the input side is ready; its result is
// presented once it has passed the input register and the result register.
// The whole state update is a single pass of logic between those two registers.
// A stalled result register holds the input register, and the input side
// stays ready while the input register is empty or moving on.
// Reset clears all counters, lengths, levels and the fill position.
`timescale 1ns / 1ps
`default_nettype none
module multichannel_delay_pulse_generator (
	input wire logic clk,
	input wire logic arst_n,
	mdpg_in_if.sink item,
	mdpg_out_if.source result
);
	import mdpg_pkg::*;

	logic valid_s1;
	logic operation_s1;
	char_t rx_byte_s1;

	count_t delay_left_q [CHANNELS];
	count_t high_left_q [CHANNELS];
	count_t low_left_q [CHANNELS];
	count_t delay_len_q [CHANNELS];
	count_t high_len_q [CHANNELS];
	count_t low_len_q [CHANNELS];
	logic level_q [CHANNELS];
	char_t store_q [CMD_LEN];
	count_t fill_q;

	logic out_valid_q;
	logic [LEVELS_W-1:0] outputs_on_q;
	logic error_q;
	logic applied_q;

	count_t delay_left_d [CHANNELS];
	count_t high_left_d [CHANNELS];
	count_t low_left_d [CHANNELS];
	count_t delay_len_d [CHANNELS];
	count_t high_len_d [CHANNELS];
	count_t low_len_d [CHANNELS];
	logic level_d [CHANNELS];
	count_t fill_d;
	count_t pos;
	logic store_en;
	logic error_d;
	logic applied_d;
	logic [LEVELS_W-1:0] levels_d;
	char_t ch_val, d_val, h_val, l_val;
	logic fmt_ok;

	logic advance;
	logic fire;

	assign advance = !out_valid_q || result.ready;
	assign fire = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;

	assign result.valid = out_valid_q;
	assign result.outputs_on = outputs_on_q;
	assign result.command_error = error_q;
	assign result.command_applied = applied_q;

	always_comb begin
		delay_left_d = delay_left_q;
		high_left_d = high_left_q;
		low_left_d = low_left_q;
		delay_len_d = delay_len_q;
		high_len_d = high_len_q;
		low_len_d = low_len_q;
		level_d = level_q;
		fill_d = fill_q;
		store_en = 1'b0;
		error_d = 1'b0;
		applied_d = 1'b0;
		levels_d = '0;

		if (rx_byte_s1 == CHAR_A || fill_q > LAST_POS) begin
			pos = '0;
		end else begin
			pos = fill_q;
		end

		ch_val = store_q[4] - DIGIT_BASE;
		d_val = store_q[6] - DIGIT_BASE;
		h_val = store_q[8] - DIGIT_BASE;
		l_val = rx_byte_s1 - DIGIT_BASE;
		fmt_ok = store_q[0] == CHAR_A && store_q[1] == CHAR_T && store_q[2] == CHAR_PLUS
			&& store_q[3] == CHAR_C && store_q[5] == CHAR_EQ && store_q[7] == CHAR_PLUS
			&& store_q[9] == CHAR_PLUS && d_val <= DIGIT_MAX && h_val <= DIGIT_MAX
			&& l_val <= DIGIT_MAX && ch_val < 8'(CHANNELS);

		if (operation_s1 == OP_TICK) begin
			for (int c = 0; c < CHANNELS; c++) begin
				if (delay_left_q[c] != '0) begin
					delay_left_d[c] = delay_left_q[c] - 4'd1;
					level_d[c] = 1'b0;
				end else if (high_left_q[c] != '0) begin
					high_left_d[c] = high_left_q[c] - 4'd1;
					level_d[c] = 1'b1;
				end else if (low_left_q[c] != '0) begin
					low_left_d[c] = low_left_q[c] - 4'd1;
					level_d[c] = 1'b0;
				end else begin
					delay_left_d[c] = delay_len_q[c];
					high_left_d[c] = high_len_q[c];
					low_left_d[c] = low_len_q[c];
				end
			end
		end else if (rx_byte_s1 != '0) begin
			store_en = 1'b1;
			if (pos == LAST_POS) begin
				fill_d = '0;
				if (fmt_ok) begin
					applied_d = 1'b1;
					for (int c = 0; c < CHANNELS; c++) begin
						if (ch_val == 8'(c)) begin
							delay_len_d[c] = d_val[3:0];
							high_len_d[c] = h_val[3:0];
							low_len_d[c] = l_val[3:0];
						end
						delay_left_d[c] = delay_len_d[c];
						high_left_d[c] = high_len_d[c];
						low_left_d[c] = low_len_d[c];
						level_d[c] = 1'b0;
					end
				end else begin
					error_d = 1'b1;
				end
			end else begin
				fill_d = pos + 4'd1;
			end
		end

		for (int c = 0; c < CHANNELS && c < LEVELS_W; c++) begin
			levels_d[c] = level_d[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			operation_s1 <= item.operation;
			rx_byte_s1 <= item.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				delay_left_q[c] <= '0;
				high_left_q[c] <= '0;
				low_left_q[c] <= '0;
				delay_len_q[c] <= '0;
				high_len_q[c] <= '0;
				low_len_q[c] <= '0;
				level_q[c] <= 1'b0;
			end
			fill_q <= '0;
		end else if (fire) begin
			delay_left_q <= delay_left_d;
			high_left_q <= high_left_d;
			low_left_q <= low_left_d;
			delay_len_q <= delay_len_d;
			high_len_q <= high_len_d;
			low_len_q <= low_len_d;
			level_q <= level_d;
			fill_q <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && store_en) begin
			for (int i = 0; i < CMD_LEN; i++) begin
				if (pos == 4'(i)) begin
					store_q[i] <= rx_byte_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			outputs_on_q <= levels_d;
			error_q <= error_d;
			applied_q <= applied_d;
		end
	end

endmodule
`default_nettype wire
